[hdl/arpc_pkg.sv]
`default_nettype none

package arpc_pkg;

    // field widths
    localparam int IP_W     = 32;
    localparam int MAC_W    = 48;
    localparam int AGE_W    = 8;
    localparam int LEN_W    = 11;
    localparam int TYPE_W   = 16;
    localparam int ALEN_W   = 8;
    localparam int OP_W     = 16;
    localparam int STATUS_W = 3;
    localparam int AGED_W   = 9;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 48;

    localparam logic [CFG_IDX_W-1:0] REG_OWN_IP        = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OWN_MAC       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ENTRY_TIMEOUT = 2'd2;

    localparam logic [AGE_W-1:0] TIMEOUT_RESET = 8'd5;

    // item kinds
    localparam logic CMD_PACKET = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    // header checks
    localparam logic [LEN_W-1:0]  MIN_FRAME_LEN = 11'd42;
    localparam logic [TYPE_W-1:0] HTYPE_ETHER   = 16'h0001;
    localparam logic [TYPE_W-1:0] PTYPE_IPV4    = 16'h0800;
    localparam logic [ALEN_W-1:0] HLEN_ETHER    = 8'h06;
    localparam logic [ALEN_W-1:0] PLEN_IPV4     = 8'h04;
    localparam logic [OP_W-1:0]   OP_REQUEST    = 16'h0001;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_SHORT   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BADFMT  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NOTUS   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_ACCEPT  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_REPLIED = 3'd4;
    localparam logic [STATUS_W-1:0] ST_TICK    = 3'd5;

    typedef struct packed {
        logic              cmd;
        logic [LEN_W-1:0]  frame_len;
        logic [TYPE_W-1:0] hw_type;
        logic [TYPE_W-1:0] proto_type;
        logic [ALEN_W-1:0] hw_len;
        logic [ALEN_W-1:0] proto_len;
        logic [OP_W-1:0]   opcode;
        logic [MAC_W-1:0]  sender_mac;
        logic [IP_W-1:0]   sender_ip;
        logic [IP_W-1:0]   target_ip;
    } item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                send_reply;
        logic                merged;
        logic                table_full;
        logic [MAC_W-1:0]    reply_target_mac;
        logic [IP_W-1:0]     reply_target_ip;
        logic [AGED_W-1:0]   aged_count;
    } result_t;

    // one cache entry as held in the ram
    typedef struct packed {
        logic [IP_W-1:0]  ip;
        logic [MAC_W-1:0] mac;
        logic [AGE_W-1:0] age;
    } entry_t;

    typedef struct packed {
        logic capture;
        logic walk_start;
        logic walk_step;
        logic update;
        logic load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic is_tick;
        logic pkt_ok;
        logic walk_last;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

[hdl/arpc_ram.sv]
`default_nettype none

module arpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

[hdl/arpc_ctrl.sv]
`default_nettype none

module arpc_ctrl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire arpc_pkg::dp_status_t stat,
    output arpc_pkg::ctrl_cmd_t       cmd
);

    import arpc_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_DECODE = 5'b00010,
        S_WALK   = 5'b00100,
        S_UPDATE = 5'b01000,
        S_DONE   = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE: begin
                cmd.capture = s_valid;
                if (s_valid) begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                cmd.walk_start = 1'b1;
                if (stat.is_tick || stat.pkt_ok) begin
                    state_next = S_WALK;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_WALK: begin
                cmd.walk_step = 1'b1;
                if (stat.walk_last) begin
                    state_next = stat.is_tick ? S_DONE : S_UPDATE;
                end
            end
            S_UPDATE: begin
                cmd.update = 1'b1;
                state_next = S_DONE;
            end
            S_DONE: begin
                cmd.load_out = stat.out_free;
                if (stat.out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

[hdl/arpc_dp.sv]
`default_nettype none

module arpc_dp #(
    parameter int CACHE_ENTRIES = 16
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_wr_en,
    input  wire logic [arpc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [arpc_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  wire arpc_pkg::item_t                     s_item,
    input  wire arpc_pkg::ctrl_cmd_t                 cmd,
    output arpc_pkg::dp_status_t                     stat,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output arpc_pkg::result_t                        m_result
);

    import arpc_pkg::*;

    localparam int IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(CACHE_ENTRIES + 1);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CACHE_ENTRIES);

    logic [IP_W-1:0]            own_ip_reg;
    logic [AGE_W-1:0]           timeout_reg;
    item_t                      item_reg;
    logic [CACHE_ENTRIES-1:0]   valid_reg;
    logic [CACHE_ENTRIES-1:0]   valid_next;
    logic [CNT_W-1:0]           cnt_reg;
    logic                       pend_vld_reg;
    logic [IDX_W-1:0]           pend_idx_reg;
    logic                       hit_reg;
    logic [IDX_W-1:0]           hit_idx_reg;
    logic                       free_reg;
    logic [IDX_W-1:0]           free_idx_reg;
    logic [AGED_W-1:0]          aged_reg;
    logic                       m_valid_reg;
    result_t                    m_result_reg;

    entry_t                     rd_entry;
    entry_t                     wr_entry;
    logic                       wr_en;
    logic [IDX_W-1:0]           wr_addr;
    logic                       is_tick;
    logic                       fmt_ok;
    logic                       for_us;
    logic                       pend_bit;
    logic [AGE_W-1:0]           age_inc;
    logic                       expire;
    logic                       tick_proc;
    logic                       match;
    logic                       free_seen;
    logic                       refresh;
    logic                       insert;
    result_t                    res;

    arpc_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (CACHE_ENTRIES)
    ) u_entry_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_entry),
        .rd_addr (cnt_reg[IDX_W-1:0]),
        .rd_data (rd_entry)
    );

    // item classification
    assign is_tick = (item_reg.cmd == CMD_TICK);
    assign fmt_ok  = (item_reg.hw_type == HTYPE_ETHER) && (item_reg.hw_len == HLEN_ETHER)
                  && (item_reg.proto_type == PTYPE_IPV4) && (item_reg.proto_len == PLEN_IPV4);
    assign for_us  = (item_reg.target_ip == own_ip_reg);

    assign stat.is_tick   = is_tick;
    assign stat.pkt_ok    = (item_reg.frame_len >= MIN_FRAME_LEN) && fmt_ok;
    assign stat.walk_last = (cnt_reg == CNT_LAST);
    assign stat.out_free  = !m_valid_reg || m_ready;

    // per-entry work on the word returned by the ram
    assign pend_bit  = valid_reg[pend_idx_reg];
    assign age_inc   = (rd_entry.age == '1) ? rd_entry.age : rd_entry.age + AGE_W'(1);
    assign expire    = (age_inc > timeout_reg);
    assign tick_proc = pend_vld_reg && is_tick && pend_bit;
    assign match     = pend_vld_reg && !is_tick && pend_bit
                    && (rd_entry.ip == item_reg.sender_ip);
    assign free_seen = pend_vld_reg && !is_tick && !pend_bit;

    assign refresh = cmd.update && hit_reg;
    assign insert  = cmd.update && !hit_reg && for_us && free_reg;

    always_comb begin
        wr_en   = tick_proc || refresh || insert;
        wr_addr = free_idx_reg;
        wr_entry.ip  = item_reg.sender_ip;
        wr_entry.mac = item_reg.sender_mac;
        wr_entry.age = '0;
        if (tick_proc) begin
            wr_addr      = pend_idx_reg;
            wr_entry.ip  = rd_entry.ip;
            wr_entry.mac = rd_entry.mac;
            wr_entry.age = age_inc;
        end else if (hit_reg) begin
            wr_addr = hit_idx_reg;
        end
    end

    always_comb begin
        valid_next = valid_reg;
        if (tick_proc && expire) begin
            valid_next[pend_idx_reg] = 1'b0;
        end
        if (insert) begin
            valid_next[free_idx_reg] = 1'b1;
        end
    end

    always_comb begin
        res = '0;
        priority if (is_tick) begin
            res.status     = ST_TICK;
            res.aged_count = aged_reg;
        end else if (item_reg.frame_len < MIN_FRAME_LEN) begin
            res.status = ST_SHORT;
        end else if (!fmt_ok) begin
            res.status = ST_BADFMT;
        end else if (!for_us) begin
            res.status = ST_NOTUS;
            res.merged = hit_reg;
        end else if (item_reg.opcode == OP_REQUEST) begin
            res.status           = ST_REPLIED;
            res.send_reply       = 1'b1;
            res.merged           = hit_reg;
            res.table_full       = !hit_reg && !free_reg;
            res.reply_target_mac = item_reg.sender_mac;
            res.reply_target_ip  = item_reg.sender_ip;
        end else begin
            res.status     = ST_ACCEPT;
            res.merged     = hit_reg;
            res.table_full = !hit_reg && !free_reg;
        end
    end

    // configuration; own mac is the reply sender and is held by the transmit side
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            own_ip_reg  <= '0;
            timeout_reg <= TIMEOUT_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_OWN_IP:        own_ip_reg  <= cfg_wdata[IP_W-1:0];
                REG_OWN_MAC:       ;
                REG_ENTRY_TIMEOUT: timeout_reg <= cfg_wdata[AGE_W-1:0];
                default:           ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            item_reg <= s_item;
        end
        if (cmd.walk_step) begin
            pend_idx_reg <= cnt_reg[IDX_W-1:0];
        end
        if (match && !hit_reg) begin
            hit_idx_reg <= pend_idx_reg;
        end
        if (free_seen && !free_reg) begin
            free_idx_reg <= pend_idx_reg;
        end
        if (cmd.load_out) begin
            m_result_reg <= res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            cnt_reg      <= '0;
            pend_vld_reg <= 1'b0;
            hit_reg      <= 1'b0;
            free_reg     <= 1'b0;
            aged_reg     <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            if (cmd.walk_start) begin
                cnt_reg      <= '0;
                pend_vld_reg <= 1'b0;
                hit_reg      <= 1'b0;
                free_reg     <= 1'b0;
                aged_reg     <= '0;
            end else begin
                if (cmd.walk_step) begin
                    pend_vld_reg <= (cnt_reg != CNT_LAST);
                    if (cnt_reg != CNT_LAST) begin
                        cnt_reg <= cnt_reg + CNT_W'(1);
                    end
                end
                if (match) begin
                    hit_reg <= 1'b1;
                end
                if (free_seen) begin
                    free_reg <= 1'b1;
                end
                if (tick_proc && expire) begin
                    aged_reg <= aged_reg + AGED_W'(1);
                end
            end
            if (cmd.load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_result = m_result_reg;

endmodule

`default_nettype wire

[hdl/arp_responder_with_aging_cache.sv]
// arp responder with an aging address cache, one item at a time
// short or malformed frames go from decode straight to the output register;
//   ticks walk the cache, checked packets walk it and then write back
// a new item is taken only once the last result is in the output register;
//   the walk reads one cache entry per cycle through the single entry ram read port
// reset: aresetn synchronous active low, clears all entries' valid bits at once
`default_nettype none

module arp_responder_with_aging_cache #(
    parameter int CACHE_ENTRIES = 16
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,

    // configuration writes
    input  wire logic                               cfg_wr_en,
    input  wire logic [arpc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [arpc_pkg::CFG_DATA_W-1:0]    cfg_wdata,

    // input items
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic                               s_cmd,
    input  wire logic [arpc_pkg::LEN_W-1:0]         s_frame_len,
    input  wire logic [arpc_pkg::TYPE_W-1:0]        s_hw_type,
    input  wire logic [arpc_pkg::TYPE_W-1:0]        s_proto_type,
    input  wire logic [arpc_pkg::ALEN_W-1:0]        s_hw_len,
    input  wire logic [arpc_pkg::ALEN_W-1:0]        s_proto_len,
    input  wire logic [arpc_pkg::OP_W-1:0]          s_opcode,
    input  wire logic [arpc_pkg::MAC_W-1:0]         s_sender_mac,
    input  wire logic [arpc_pkg::IP_W-1:0]          s_sender_ip,
    input  wire logic [arpc_pkg::IP_W-1:0]          s_target_ip,

    // result items
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic [arpc_pkg::STATUS_W-1:0]           m_status,
    output logic                                    m_send_reply,
    output logic                                    m_merged,
    output logic                                    m_table_full,
    output logic [arpc_pkg::MAC_W-1:0]              m_reply_target_mac,
    output logic [arpc_pkg::IP_W-1:0]               m_reply_target_ip,
    output logic [arpc_pkg::AGED_W-1:0]             m_aged_count
);

    import arpc_pkg::*;

    item_t      s_item;
    result_t    m_result;
    ctrl_cmd_t  cmd;
    dp_status_t stat;

    // gather the input fields into one item
    assign s_item.cmd        = s_cmd;
    assign s_item.frame_len  = s_frame_len;
    assign s_item.hw_type    = s_hw_type;
    assign s_item.proto_type = s_proto_type;
    assign s_item.hw_len     = s_hw_len;
    assign s_item.proto_len  = s_proto_len;
    assign s_item.opcode     = s_opcode;
    assign s_item.sender_mac = s_sender_mac;
    assign s_item.sender_ip  = s_sender_ip;
    assign s_item.target_ip  = s_target_ip;

    // sequencer: idle, decode, walk over the cache, write back, hand over the item
    arpc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // datapath: config registers, valid bits, entry ram, lookup flags, output register
    arpc_dp #(
        .CACHE_ENTRIES (CACHE_ENTRIES)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_item    (s_item),
        .cmd       (cmd),
        .stat      (stat),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_result  (m_result)
    );

    // spread the result item onto its ports
    assign m_status           = m_result.status;
    assign m_send_reply       = m_result.send_reply;
    assign m_merged           = m_result.merged;
    assign m_table_full       = m_result.table_full;
    assign m_reply_target_mac = m_result.reply_target_mac;
    assign m_reply_target_ip  = m_result.reply_target_ip;
    assign m_aged_count       = m_result.aged_count;

endmodule

`default_nettype wire

[hdl/arpc_checker.sv]
`default_nettype none

module arpc_checker (
    input wire logic                               aclk,
    input wire logic                               aresetn,
    input wire logic                               s_valid,
    input wire logic                               s_ready,
    input wire logic                               m_valid,
    input wire logic                               m_ready,
    input wire logic [arpc_pkg::STATUS_W-1:0]      m_status,
    input wire logic                               m_send_reply,
    input wire logic                               m_merged,
    input wire logic                               m_table_full,
    input wire logic [arpc_pkg::AGED_W-1:0]        m_aged_count
);

    import arpc_pkg::*;

    // one item at a time: after an accept the input side closes
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input still ready after accepting an item");

    // a waiting result holds
    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_aged_count))
        else $error("result changed while stalled");

    a_reply_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_send_reply |-> m_status == ST_REPLIED)
        else $error("reply flagged without replied status");

    a_tick_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != ST_TICK |-> m_aged_count == '0)
        else $error("aged count on a packet result");

    a_drop_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == ST_SHORT || m_status == ST_BADFMT || m_status == ST_TICK)
        |-> !m_merged && !m_table_full && !m_send_reply)
        else $error("cache flags on a dropped frame or tick");

endmodule

bind arp_responder_with_aging_cache arpc_checker u_arpc_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_status     (m_status),
    .m_send_reply (m_send_reply),
    .m_merged     (m_merged),
    .m_table_full (m_table_full),
    .m_aged_count (m_aged_count)
);

`default_nettype wire
